/* sv/msba_pkg.sv */
`default_nettype none
package msba_pkg;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_PUSHED  = 2'd0,
    ST_POPPED  = 2'd1,
    ST_DROPPED = 2'd2,
    ST_EMPTY   = 2'd3
  } status_t;

  typedef struct packed {
    logic        op;
    logic [9:0]  stack_id;
    logic [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic [31:0] popped_value;
    logic [1:0]  status;
  } out_item_t;

endpackage
`default_nettype wire

/* sv/multi_stack_block_allocator_core.sv */
`default_nettype none
// Multi-stack block allocator.
// Many stacks share one data memory cut into blocks of BLOCK_WORDS words; word 0
// of each block is a link slot, kept in a separate link memory.
// Input channel: present in_item with start high; it is taken when busy is low.
// Result channel: out_valid is high for exactly one cycle with out_item; there is
// no back-pressure, the receiver must take it.
// Each transaction: the accepting edge (S_IDLE) reads the stack top table, S_RD
// reads the data/link/free-stack memories, and S_EXE writes back and registers
// the result and raises out_valid. One transaction at a time: a new one is taken
// only after the result is registered (busy covers the rest).
// After reset a clearing pass walks the top table and the link-valid memory,
// during which busy is high.
// Stack s starts owning block s, with no predecessor.
module multi_stack_block_allocator_core #(
  parameter int NUM_STACKS  = 1024,
  parameter int BLOCK_WORDS = 16,
  parameter int NUM_BLOCKS  = 8192,
  parameter int DATA_WIDTH  = 32
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 start,
  output logic                busy,
  input  msba_pkg::in_item_t  in_item,
  output logic                out_valid,
  output msba_pkg::out_item_t out_item
);
  import msba_pkg::*;

  localparam int BW    = $clog2(BLOCK_WORDS);
  localparam int BLKW  = $clog2(NUM_BLOCKS + 1);
  localparam int BIDW  = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int SLW   = BLKW + BW + 1;
  localparam int SIDW  = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
  localparam int TOTAL = NUM_BLOCKS * BLOCK_WORDS;
  localparam int AW    = $clog2(TOTAL);
  localparam int CLRN  = (NUM_STACKS > NUM_BLOCKS) ? NUM_STACKS : NUM_BLOCKS;
  localparam int CLRW  = $clog2(CLRN + 1);
  localparam logic [SLW-1:0] BWS = SLW'(BLOCK_WORDS);

  typedef enum logic [2:0] {S_CLR, S_IDLE, S_RD, S_EXE} state_t;

  logic [DATA_WIDTH-1:0] data_mem [TOTAL];
  logic [SLW-1:0]        top_mem  [NUM_STACKS];
  logic [SLW:0]          link_mem [NUM_BLOCKS];
  logic [BIDW-1:0]       free_mem [NUM_BLOCKS];

  state_t          state_r;
  logic [CLRW-1:0] clr_r;
  in_item_t        req_r;
  logic [BLKW-1:0] bump_r;
  logic [BLKW-1:0] fcnt_r;
  logic [SLW-1:0]  top_r;
  logic [DATA_WIDTH-1:0] data_r;
  logic [SLW:0]    link_r;
  logic [BIDW-1:0] free_r;
  out_item_t       out_r;
  logic            ov_r;

  logic [SIDW-1:0] sid;
  logic            sid_ok;
  logic [SLW-1:0]  tdec;
  logic [SLW-1:0]  dblk;
  logic [SLW-1:0]  nblk;

  assign sid    = req_r.stack_id[SIDW-1:0];
  assign sid_ok = 32'(req_r.stack_id) < NUM_STACKS;
  assign tdec   = top_r - SLW'(1);
  assign dblk   = tdec / BWS;
  assign nblk   = (32'(bump_r) < NUM_BLOCKS) ? SLW'(bump_r) :
                  SLW'(free_r);

  logic push_full, get_ok, pop_empty, frees;
  always_comb begin
    push_full = (top_r % BWS) == '0;
    get_ok    = (32'(bump_r) < NUM_BLOCKS) || (fcnt_r != '0);
    pop_empty = ((top_r % BWS) == SLW'(1)) || (top_r == '0);
    frees     = ((tdec % BWS) == SLW'(1)) && (32'(dblk) < NUM_BLOCKS) &&
                link_r[SLW];
  end

  // reads: stack top table at acceptance, data/link/free-stack memories in stage RD
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && start)
      top_r <= top_mem[in_item.stack_id[SIDW-1:0]];
    if (state_r == S_RD) begin
      data_r <= data_mem[AW'(top_r - SLW'(1))];
      link_r <= link_mem[BIDW'(dblk)];
      free_r <= free_mem[BIDW'(fcnt_r - BLKW'(1))];
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_CLR) begin
      if (32'(clr_r) < NUM_STACKS)
        top_mem[SIDW'(clr_r)] <= SLW'(clr_r) * BWS + SLW'(1);
      if (32'(clr_r) < NUM_BLOCKS)
        link_mem[BIDW'(clr_r)] <= '0;
    end else if (state_r == S_EXE && sid_ok) begin
      if (req_r.op == OP_PUSH) begin
        if (!push_full) begin
          if (32'(top_r) < TOTAL)
            data_mem[AW'(top_r)] <= DATA_WIDTH'(req_r.value);
          top_mem[sid] <= top_r + SLW'(1);
        end else if (get_ok && 32'(nblk) < NUM_BLOCKS) begin
          link_mem[BIDW'(nblk)] <= {1'b1, tdec};
          data_mem[AW'(nblk * BWS + SLW'(1))] <= DATA_WIDTH'(req_r.value);
          top_mem[sid] <= nblk * BWS + SLW'(2);
        end
      end else if (!pop_empty) begin
        if (frees) begin
          top_mem[sid] <= link_r[SLW-1:0] + SLW'(1);
          link_mem[BIDW'(dblk)] <= '0;
          if (!(SLW'(bump_r) == dblk + SLW'(1)) && 32'(fcnt_r) < NUM_BLOCKS)
            free_mem[BIDW'(fcnt_r)] <= BIDW'(dblk);
        end else begin
          top_mem[sid] <= tdec;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      clr_r   <= '0;
      bump_r  <= BLKW'(NUM_STACKS);
      fcnt_r  <= '0;
      ov_r    <= 1'b0;
    end else begin
      ov_r <= 1'b0;
      unique case (state_r)
        S_CLR: begin
          clr_r <= clr_r + CLRW'(1);
          if (32'(clr_r) == CLRN - 1) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (start) begin
            req_r   <= in_item;
            state_r <= S_RD;
          end
        end
        S_RD: state_r <= S_EXE;
        S_EXE: begin
          state_r <= S_IDLE;
          ov_r    <= 1'b1;
          out_r.popped_value <= '0;
          if (req_r.op == OP_PUSH) begin
            if (!sid_ok) out_r.status <= ST_DROPPED;
            else if (!push_full) out_r.status <= ST_PUSHED;
            else if (get_ok) begin
              if (32'(bump_r) < NUM_BLOCKS) bump_r <= bump_r + BLKW'(1);
              else fcnt_r <= fcnt_r - BLKW'(1);
              out_r.status <= (32'(nblk) < NUM_BLOCKS) ? ST_PUSHED : ST_DROPPED;
            end else out_r.status <= ST_DROPPED;
          end else begin
            if (!sid_ok || pop_empty) out_r.status <= ST_EMPTY;
            else begin
              out_r.status <= ST_POPPED;
              out_r.popped_value <= (32'(tdec) < TOTAL) ? 32'(data_r) : '0;
              if (frees) begin
                if (SLW'(bump_r) == dblk + SLW'(1)) bump_r <= bump_r - BLKW'(1);
                else if (32'(fcnt_r) < NUM_BLOCKS) fcnt_r <= fcnt_r + BLKW'(1);
              end
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy      = state_r != S_IDLE;
  assign out_valid = ov_r;
  assign out_item  = out_r;

`ifndef SYNTHESIS
  a_one_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe held");
  a_three: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && start) |-> ##3 out_valid) else $error("latency");
  a_bump: assert property (@(posedge clk) disable iff (!rst_n)
    32'(bump_r) <= NUM_BLOCKS) else $error("bump overrun");
  a_free: assert property (@(posedge clk) disable iff (!rst_n)
    32'(fcnt_r) <= NUM_BLOCKS) else $error("free count overrun");
`endif

endmodule
`default_nettype wire

/* verif/multi_stack_block_allocator_core_test.sv */
`default_nettype none
module multi_stack_block_allocator_core_test;
  import msba_pkg::*;

  localparam int NUM_STACKS  = 1024;
  localparam int BLOCK_WORDS = 16;
  localparam int NUM_BLOCKS  = 8192;
  localparam int N_RANDOM    = 800;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_item;
  logic      out_valid;
  out_item_t out_item;

  multi_stack_block_allocator_core dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_item(in_item), .out_valid(out_valid), .out_item(out_item)
  );

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  // shadow allocator state
  logic [31:0] mem_words [int];
  logic [17:0] link_slot [NUM_BLOCKS];
  bit          link_ok   [NUM_BLOCKS];
  logic [17:0] top_of    [NUM_STACKS];
  int unsigned bump_ptr;
  logic [12:0] freed     [NUM_BLOCKS];
  int unsigned freed_cnt;

  out_item_t pending_results [$];
  int        n_errors = 0;
  int        n_row_errors;
  int        n_results = 0;
  int        n_pops = 0, n_drops = 0, n_empties = 0;

  function automatic out_item_t allocate_or_pop(in_item_t it);
    out_item_t   r;
    int unsigned t, b;
    bit          got;
    r = '0;
    if (it.op == OP_PUSH) begin
      t = top_of[it.stack_id];
      if (t % BLOCK_WORDS != 0) begin
        mem_words[t] = it.value;
        top_of[it.stack_id] = 18'(t + 1);
        r.status = ST_PUSHED;
      end else begin
        got = 1'b1;
        b = 0;
        if (bump_ptr < NUM_BLOCKS) begin
          b = bump_ptr;
          bump_ptr++;
        end else if (freed_cnt > 0) begin
          freed_cnt--;
          b = freed[freed_cnt];
        end else begin
          got = 1'b0;
        end
        if (got) begin
          link_slot[b] = 18'(t - 1);
          link_ok[b] = 1'b1;
          mem_words[b * BLOCK_WORDS + 1] = it.value;
          top_of[it.stack_id] = 18'(b * BLOCK_WORDS + 2);
          r.status = ST_PUSHED;
        end else begin
          r.status = ST_DROPPED;
        end
      end
    end else begin
      t = top_of[it.stack_id];
      if (t % BLOCK_WORDS == 1 || t == 0) begin
        r.status = ST_EMPTY;
      end else begin
        t--;
        r.popped_value = mem_words.exists(t) ? mem_words[t] : 32'd0;
        top_of[it.stack_id] = 18'(t);
        if (t % BLOCK_WORDS == 1) begin
          b = t / BLOCK_WORDS;
          if (link_ok[b]) begin
            if (b + 1 == bump_ptr) bump_ptr--;
            else if (freed_cnt < NUM_BLOCKS) begin
              freed[freed_cnt] = 13'(b);
              freed_cnt++;
            end
            top_of[it.stack_id] = link_slot[b] + 18'd1;
            link_ok[b] = 1'b0;
          end
        end
        r.status = ST_POPPED;
      end
    end
    return r;
  endfunction

  task automatic send_transaction(in_item_t it, bit idle_ok);
    if (idle_ok && $urandom_range(99) < 32) begin
      start <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < 32) @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_results.push_back(allocate_or_pop(it));
  endtask

  task automatic drain;
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic in_item_t mk(op_t o, int sid, logic [31:0] v);
    in_item_t it;
    it.op = o;
    it.stack_id = 10'(sid);
    it.value = v;
    return it;
  endfunction

  // result checker
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid) begin
      n_results++;
      if (pending_results.size() == 0) begin
        $error("unexpected transaction: popped_value %h status %0d",
               out_item.popped_value, out_item.status);
        n_errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_item.popped_value !== want.popped_value) begin
          $error("popped_value: expected %h actual %h",
                 want.popped_value, out_item.popped_value);
          n_errors++;
        end
        if (out_item.status !== want.status) begin
          $error("status: expected %0d actual %0d", want.status, out_item.status);
          n_errors++;
        end
        if (want.status == ST_POPPED) n_pops++;
        if (want.status == ST_DROPPED) n_drops++;
        if (want.status == ST_EMPTY) n_empties++;
      end
    end
  end

  // directed rows: op, stack, value, typed-in result (check_typed) or predictor
  typedef struct {
    op_t         o;
    int          sid;
    logic [31:0] v;
    bit          check_typed;
    logic [31:0] want_val;
    status_t     want_st;
  } row_t;

  row_t dir_rows [11] = '{
    '{OP_POP,  0,    32'h0,        1'b1, 32'h0,        ST_EMPTY},
    '{OP_POP,  1023, 32'h0,        1'b1, 32'h0,        ST_EMPTY},
    '{OP_PUSH, 0,    32'h0,        1'b1, 32'h0,        ST_PUSHED},
    '{OP_PUSH, 1023, 32'hFFFFFFFF, 1'b1, 32'h0,        ST_PUSHED},
    '{OP_POP,  1023, 32'h12345678, 1'b1, 32'hFFFFFFFF, ST_POPPED},
    '{OP_POP,  1023, 32'h0,        1'b1, 32'h0,        ST_EMPTY},
    '{OP_POP,  0,    32'hFFFFFFFF, 1'b1, 32'h0,        ST_POPPED},
    '{OP_PUSH, 512,  32'hA5A5A5A5, 1'b0, 32'h0,        ST_PUSHED},
    '{OP_PUSH, 512,  32'h5A5A5A5A, 1'b0, 32'h0,        ST_PUSHED},
    '{OP_POP,  512,  32'h0,        1'b0, 32'h0,        ST_POPPED},
    '{OP_POP,  512,  32'h0,        1'b0, 32'h0,        ST_POPPED}
  };

  initial begin
    #50_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    in_item_t  it;
    out_item_t want;
    int        sid, k, n, lim;
    n_row_errors = 0;
    for (int s = 0; s < NUM_STACKS; s++) top_of[s] = 18'(s * BLOCK_WORDS + 1);
    for (int b = 0; b < NUM_BLOCKS; b++) link_ok[b] = 1'b0;
    bump_ptr = NUM_STACKS;
    freed_cnt = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_item = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      it = mk(dir_rows[i].o, dir_rows[i].sid, dir_rows[i].v);
      send_transaction(it, 1'b1);
      if (dir_rows[i].check_typed) begin
        want = pending_results[$];
        if (want.popped_value !== dir_rows[i].want_val || want.status !== dir_rows[i].want_st)
          begin
          $error("directed row %0d: predictor disagrees with typed result", i);
          n_row_errors++;
        end
      end
    end
    // chain across blocks on stack 7: fill two blocks and part of a third, then unwind to empty
    for (k = 0; k < 40; k++) send_transaction(mk(OP_PUSH, 7, $urandom()), 1'b1);
    for (k = 0; k < 41; k++) send_transaction(mk(OP_POP, 7, $urandom()), 1'b1);
    drain();

    // random: mostly bursts of pushes then pops on a few hot stacks, some noise
    n = 0;
    while (n < N_RANDOM) begin
      sid = $urandom_range(3) == 0 ? $urandom_range(1023) : $urandom_range(7);
      lim = $urandom_range(1, 40);
      for (k = 0; k < lim; k++) begin
        send_transaction(mk(OP_PUSH, sid, $urandom()), !(n > 300 && n < 450));
        n++;
      end
      lim = $urandom_range(1, 44);
      for (k = 0; k < lim; k++) begin
        send_transaction(mk(op_t'($urandom_range(9) != 0), sid, $urandom()),
                         !(n > 300 && n < 450));
        n++;
      end
      if ($urandom_range(15) == 0) drain();
    end

    for (k = 0; k < 100; k++)
      send_transaction(mk(op_t'($urandom_range(1)), $urandom_range(1023), $urandom()), 1'b1);

    drain();
    repeat (10) @(posedge clk);
    $display("%0d transactions checked: %0d pops, %0d dropped pushes, %0d empty pops",
             n_results, n_pops, n_drops, n_empties);
    if (n_errors == 0 && n_row_errors == 0 && pending_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire
